// ===== design/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types and constants for the matrix multiply engine: opcodes,
// configuration register indexes, field widths and the pipeline tag.
// ----------------------------------------------------------------------------
package mme_pkg;

    // Default sizing of the stores and elements.
    localparam int DEF_MAX_DIM    = 64;
    localparam int DEF_ELEM_WIDTH = 16;

    // Fixed field widths.
    localparam int OP_W   = 2;
    localparam int IDX_W  = 6;
    localparam int CFG_W  = 7;
    localparam int CIDX_W = 2;
    localparam int SUM_W  = 40;

    // Reset value of the three dimension registers.
    localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

    // Request opcodes.
    localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_ROWS  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_INNER = 2'd1;
    localparam logic [CIDX_W-1:0] REG_COLS  = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // Tag that travels with each product through the MAC pipeline.
    typedef struct packed {
        logic             first;
        logic             last;
        logic             row_end;
        logic [IDX_W-1:0] col;
    } mac_tag_t;

endpackage

// ===== design/mme_ram.sv =====
// ----------------------------------------------------------------------------
// mme_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No reset on the contents.
// ----------------------------------------------------------------------------
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/matrix_multiply_engine.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Dense matrix product C = A x B. Elements of A and B are loaded into two
// RAMs; a compute request walks one row of C with one multiply-accumulate
// per cycle and returns one sum per column.
// ----------------------------------------------------------------------------
// Load requests leave busy low, and the next request can follow in the
// next cycle.
// A compute request for a valid row keeps busy high until the sequencer and
// MAC pipeline are done, the single RAM read port of each store feeding one
// MAC per cycle. Column sums pass the RAM read, product and result registers;
// a bad row returns in the next cycle. Results are strobed for one cycle and
// cannot be stalled. Reset clears control state and sets all dimensions to
// 64; the stores are not cleared and hold undefined data until written.
module matrix_multiply_engine
    import mme_pkg::*;
#(
    parameter int MAX_DIM    = DEF_MAX_DIM,
    parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Request port.
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       opcode,
    input  logic [IDX_W-1:0]      row_index,
    input  logic [IDX_W-1:0]      col_index,
    input  logic [ELEM_WIDTH-1:0] element_value,
    // Configuration port.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CIDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    // Result port.
    output logic                  result_valid,
    output logic [IDX_W-1:0]      out_row,
    output logic [IDX_W-1:0]      out_col,
    output logic [SUM_W-1:0]      product_sum,
    output logic                  last_of_row,
    output logic                  bad_row
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int IX_W  = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int EW    = (DIM_W > CFG_W) ? DIM_W : CFG_W;
    localparam int PW    = 2 * ELEM_WIDTH;

    // Clamp a dimension register to the range 1 .. MAX_DIM.
    function automatic logic [EW-1:0] clamp_dim(input logic [CFG_W-1:0] r);
        if (r == '0)
        begin
            return EW'(1);
        end
        if (EW'(r) > EW'(MAX_DIM))
        begin
            return EW'(MAX_DIM);
        end
        return EW'(r);
    endfunction

    // Configuration registers.
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] inner_reg;
    logic [CFG_W-1:0] cols_reg;
    logic [EW-1:0]    dim_m;
    logic [EW-1:0]    dim_n;
    logic [EW-1:0]    dim_k;

    // Sequencer.
    state_t           state_reg;
    state_t           state_next;
    logic [IX_W-1:0]  l_reg;
    logic [IX_W-1:0]  l_next;
    logic [IX_W-1:0]  j_reg;
    logic [IX_W-1:0]  j_next;
    logic [IDX_W-1:0] row_reg;
    logic [IDX_W-1:0] row_next;

    // Pipeline.
    logic             s1_v_reg;
    mac_tag_t         s1_tag_reg;
    logic             s2_v_reg;
    mac_tag_t         s2_tag_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    logic [SUM_W-1:0] acc_reg;
    logic [SUM_W-1:0] acc_next;

    // Result registers.
    logic             res_valid_reg;
    logic             res_valid_next;
    logic [IDX_W-1:0] res_row_reg;
    logic [IDX_W-1:0] res_row_next;
    logic [IDX_W-1:0] res_col_reg;
    logic [IDX_W-1:0] res_col_next;
    logic [SUM_W-1:0] res_sum_reg;
    logic [SUM_W-1:0] res_sum_next;
    logic             res_last_reg;
    logic             res_last_next;
    logic             res_bad_reg;
    logic             res_bad_next;

    // Request decode and RAM ports.
    logic                  accept;
    logic                  ld_a;
    logic                  ld_b;
    logic                  row_ok;
    logic                  cmp_go;
    logic                  cmp_bad;
    logic                  issue;
    logic                  l_last;
    logic                  j_last;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         a_rd_addr;
    logic [AW-1:0]         b_rd_addr;
    logic [ELEM_WIDTH-1:0] a_rd_data;
    logic [ELEM_WIDTH-1:0] b_rd_data;
    logic signed [63:0]    prod_wide;
    logic [SUM_W-1:0]      prod_ext;
    mac_tag_t              issue_tag;

    // Configuration writes; index 3 is ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= DIM_RESET;
            inner_reg <= DIM_RESET;
            cols_reg  <= DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROWS:  rows_reg  <= cfg_data;
                REG_INNER: inner_reg <= cfg_data;
                REG_COLS:  cols_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign dim_m = clamp_dim(rows_reg);
    assign dim_n = clamp_dim(inner_reg);
    assign dim_k = clamp_dim(cols_reg);

    // Request decode.
    assign busy    = (state_reg == ST_RUN) || s1_v_reg || s2_v_reg;
    assign accept  = start && !busy;
    assign ld_a    = accept && (opcode == OP_LOAD_A)
                     && (EW'(row_index) < dim_m) && (EW'(col_index) < dim_n);
    assign ld_b    = accept && (opcode == OP_LOAD_B)
                     && (EW'(row_index) < dim_n) && (EW'(col_index) < dim_k);
    assign row_ok  = EW'(row_index) < dim_m;
    assign cmp_go  = accept && (opcode == OP_COMPUTE) && row_ok;
    assign cmp_bad = accept && (opcode == OP_COMPUTE) && !row_ok;
    assign wr_addr = AW'(int'(row_index) * MAX_DIM + int'(col_index));

    // Address generation: A walks along the row, B down the column.
    assign issue     = (state_reg == ST_RUN);
    assign l_last    = (EW'(l_reg) + EW'(1)) == dim_n;
    assign j_last    = (EW'(j_reg) + EW'(1)) == dim_k;
    assign a_rd_addr = AW'(int'(row_reg) * MAX_DIM + int'(l_reg));
    assign b_rd_addr = AW'(int'(l_reg) * MAX_DIM + int'(j_reg));

    assign issue_tag.first   = (l_reg == '0);
    assign issue_tag.last    = l_last;
    assign issue_tag.row_end = l_last && j_last;
    assign issue_tag.col     = IDX_W'(j_reg);

    // Element stores.
    mme_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_left_ram (
        .clk     (clk),
        .wr_en   (ld_a),
        .wr_addr (wr_addr),
        .wr_data (element_value),
        .rd_en   (issue),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    mme_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_right_ram (
        .clk     (clk),
        .wr_en   (ld_b),
        .wr_addr (wr_addr),
        .wr_data (element_value),
        .rd_en   (issue),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    // Sequencer next state: inner index first, then column.
    always_comb
    begin
        state_next = state_reg;
        l_next     = l_reg;
        j_next     = j_reg;
        row_next   = row_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmp_go)
                begin
                    state_next = ST_RUN;
                    l_next     = '0;
                    j_next     = '0;
                    row_next   = row_index;
                end
            end
            ST_RUN:
            begin
                if (l_last)
                begin
                    l_next = '0;
                    if (j_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        j_next = j_reg + IX_W'(1);
                    end
                end
                else
                begin
                    l_next = l_reg + IX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            l_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            l_reg     <= l_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
    end

    // Multiply stage and accumulate stage.
    assign prod_next = $signed(a_rd_data) * $signed(b_rd_data);
    assign prod_wide = 64'(prod_reg);
    assign prod_ext  = prod_wide[SUM_W-1:0];
    assign acc_next  = s2_tag_reg.first ? prod_ext : acc_reg + prod_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= issue;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg <= issue_tag;
        s2_tag_reg <= s1_tag_reg;
        prod_reg   <= prod_next;
        if (s2_v_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // Result register: a finished column, or the bad-row reply. The two
    // never coincide, since a bad row is only accepted while idle.
    always_comb
    begin
        res_valid_next = 1'b0;
        res_row_next   = res_row_reg;
        res_col_next   = res_col_reg;
        res_sum_next   = res_sum_reg;
        res_last_next  = res_last_reg;
        res_bad_next   = res_bad_reg;
        if (s2_v_reg && s2_tag_reg.last)
        begin
            res_valid_next = 1'b1;
            res_row_next   = row_reg;
            res_col_next   = s2_tag_reg.col;
            res_sum_next   = acc_next;
            res_last_next  = s2_tag_reg.row_end;
            res_bad_next   = 1'b0;
        end
        else if (cmp_bad)
        begin
            res_valid_next = 1'b1;
            res_row_next   = row_index;
            res_col_next   = '0;
            res_sum_next   = '0;
            res_last_next  = 1'b1;
            res_bad_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_row_reg  <= res_row_next;
        res_col_reg  <= res_col_next;
        res_sum_reg  <= res_sum_next;
        res_last_reg <= res_last_next;
        res_bad_reg  <= res_bad_next;
    end

    assign result_valid = res_valid_reg;
    assign out_row      = res_row_reg;
    assign out_col      = res_col_reg;
    assign product_sum  = res_sum_reg;
    assign last_of_row  = res_last_reg;
    assign bad_row      = res_bad_reg;

endmodule

// ===== design/mme_checker.sv =====
// ----------------------------------------------------------------------------
// mme_checker
// Port-level assertions for the matrix multiply engine, bound to the top.
// ----------------------------------------------------------------------------
module mme_checker
    import mme_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic [OP_W-1:0]   opcode,
    input logic              result_valid,
    input logic [IDX_W-1:0]  out_col,
    input logic [SUM_W-1:0]  product_sum,
    input logic              last_of_row,
    input logic              bad_row
);

    // A bad-row reply is a single, closed, zero result.
    a_bad_row_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && bad_row |-> last_of_row && (out_col == '0)
                                    && (product_sum == '0))
        else $error("bad-row result has wrong shape");

    // A row still in progress keeps the engine busy.
    a_busy_mid_row: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_of_row |-> busy)
        else $error("engine idle before end of row");

    // A load request does not make the engine busy.
    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (opcode == OP_LOAD_A || opcode == OP_LOAD_B) |=> !busy)
        else $error("load request raised busy");

    // A load or unused-opcode request accepted while idle yields no result next cycle.
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && opcode != OP_COMPUTE |=> !result_valid)
        else $error("result after a load request");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .result_valid (result_valid),
    .out_col      (out_col),
    .product_sum  (product_sum),
    .last_of_row  (last_of_row),
    .bad_row      (bad_row)
);

// ===== test/matrix_multiply_engine_check.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_engine_check
// Watches the request, configuration and result ports of the matrix multiply
// engine. Keeps its own copy of both element stores and the three dimension
// registers, works out every C element a compute request must return, and
// compares each strobed result against the oldest one still owed.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_check
    import mme_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic [OP_W-1:0]           opcode,
    input  logic [IDX_W-1:0]          row_index,
    input  logic [IDX_W-1:0]          col_index,
    input  logic [DEF_ELEM_WIDTH-1:0] element_value,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CIDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      result_valid,
    input  logic [IDX_W-1:0]          out_row,
    input  logic [IDX_W-1:0]          out_col,
    input  logic [SUM_W-1:0]          product_sum,
    input  logic                      last_of_row,
    input  logic                      bad_row,
    output int                        mismatch_count,
    output int                        results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM        = DEF_MAX_DIM;

    // One element of C as the result port should present it.
    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [SUM_W-1:0] sum;
        logic             last;
        logic             bad;
    } c_elem_t;

    logic signed [DEF_ELEM_WIDTH-1:0] a_elems [DIM*DIM];
    logic signed [DEF_ELEM_WIDTH-1:0] b_elems [DIM*DIM];
    logic [CFG_W-1:0]                 rows_reg;
    logic [CFG_W-1:0]                 inner_reg;
    logic [CFG_W-1:0]                 cols_reg;
    c_elem_t                          c_elems_due [$];
    int                               fails = 0;

    // Entries are never read before they are written; zero keeps sums free of X.
    initial
    begin
        for (int i = 0; i < DIM*DIM; i++)
        begin
            a_elems[i] = '0;
            b_elems[i] = '0;
        end
    end

    // A dimension of zero counts as one, anything above the store size as the size.
    function automatic int used_dim(input logic [CFG_W-1:0] raw);
        if (raw == '0)
            return 1;
        if (raw > DIM)
            return DIM;
        return int'(raw);
    endfunction

    function automatic void flag_field(input string field, input longint want,
                                       input longint got);
        fails++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    // Queue the C elements owed for one compute request.
    function automatic void multiply_row(input logic [IDX_W-1:0] row);
        int      m;
        int      n;
        int      k;
        longint  acc;
        c_elem_t e;
        m = used_dim(rows_reg);
        n = used_dim(inner_reg);
        k = used_dim(cols_reg);
        if (row >= m)
        begin
            e.row  = row;
            e.col  = '0;
            e.sum  = '0;
            e.last = 1'b1;
            e.bad  = 1'b1;
            c_elems_due.push_back(e);
        end
        else
        begin
            for (int j = 0; j < k; j++)
            begin
                acc = 0;
                for (int l = 0; l < n; l++)
                    acc += longint'(a_elems[row*DIM + l]) * longint'(b_elems[l*DIM + j]);
                e.row  = row;
                e.col  = IDX_W'(j);
                e.sum  = acc[SUM_W-1:0];
                e.last = (j == k - 1);
                e.bad  = 1'b0;
                c_elems_due.push_back(e);
            end
        end
    endfunction

    // Results are checked before new requests are queued, since a result on
    // the same edge always belongs to an earlier request.
    always @(posedge clk or negedge rst_n)
    begin
        c_elem_t want;
        if (!rst_n)
        begin
            rows_reg  = DIM_RESET;
            inner_reg = DIM_RESET;
            cols_reg  = DIM_RESET;
        end
        else
        begin
            if (result_valid)
            begin
                if (c_elems_due.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result, expected none, got row %0d col %0d",
                             $time, out_row, out_col);
                end
                else
                begin
                    want = c_elems_due.pop_front();
                    if (out_row !== want.row)
                        flag_field("out_row", want.row, out_row);
                    if (out_col !== want.col)
                        flag_field("out_col", want.col, out_col);
                    if (product_sum !== want.sum)
                        flag_field("product_sum", $signed(want.sum), $signed(product_sum));
                    if (last_of_row !== want.last)
                        flag_field("last_of_row", want.last, last_of_row);
                    if (bad_row !== want.bad)
                        flag_field("bad_row", want.bad, bad_row);
                end
            end

            // Dimension register writes.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ROWS:  rows_reg  = cfg_data;
                    REG_INNER: inner_reg = cfg_data;
                    REG_COLS:  cols_reg  = cfg_data;
                    default: ;
                endcase
            end

            // Accepted request: loads outside the sizes are dropped.
            if (start && !busy)
            begin
                case (opcode)
                    OP_LOAD_A:
                        if (row_index < used_dim(rows_reg) && col_index < used_dim(inner_reg))
                            a_elems[row_index*DIM + col_index] = element_value;
                    OP_LOAD_B:
                        if (row_index < used_dim(inner_reg) && col_index < used_dim(cols_reg))
                            b_elems[row_index*DIM + col_index] = element_value;
                    OP_COMPUTE:
                        multiply_row(row_index);
                    default: ;
                endcase
            end
        end
        mismatch_count <= fails;
        results_due    <= c_elems_due.size();
    end

endmodule

// ===== test/matrix_multiply_engine_test.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_engine_test
// Drives the matrix multiply engine: a full row of 64 results over clamped
// dimensions, a directed small product with extreme elements, dropped loads
// and bad rows, then random phases with small random sizes and sender gaps.
// Every store entry a compute reads is loaded first. The checker beside the
// block does the comparing; this module gives the verdict.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mme_pkg::*;

    localparam int DIM           = DEF_MAX_DIM;
    localparam int QUIET_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS   = 6;

    // The opcode the block has no use for.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [DEF_ELEM_WIDTH-1:0] ELEM_MIN = {1'b1, {(DEF_ELEM_WIDTH-1){1'b0}}};
    localparam logic [DEF_ELEM_WIDTH-1:0] ELEM_MAX = {1'b0, {(DEF_ELEM_WIDTH-1){1'b1}}};

    logic                      clk;
    logic                      rst_n         = 1'b0;
    logic                      start         = 1'b0;
    logic                      busy;
    logic [OP_W-1:0]           opcode        = OP_LOAD_A;
    logic [IDX_W-1:0]          row_index     = '0;
    logic [IDX_W-1:0]          col_index     = '0;
    logic [DEF_ELEM_WIDTH-1:0] element_value = '0;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [CIDX_W-1:0]         cfg_index     = REG_ROWS;
    logic [CFG_W-1:0]          cfg_data      = '0;
    logic                      result_valid;
    logic [IDX_W-1:0]          out_row;
    logic [IDX_W-1:0]          out_col;
    logic [SUM_W-1:0]          product_sum;
    logic                      last_of_row;
    logic                      bad_row;
    int                        mismatch_count;
    int                        results_due;

    // Sender gap rate in percent, and the sizes now in force.
    int idle_pct  = 0;
    int rows_eff  = DIM;
    int inner_eff = DIM;
    int cols_eff  = DIM;

    // Which store entries hold a loaded value.
    bit a_written [DIM][DIM];
    bit b_written [DIM][DIM];

    matrix_multiply_engine dut (.*);

    matrix_multiply_engine_check c_row_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    function automatic int clamp_dim(input logic [CFG_W-1:0] raw);
        if (raw == '0)
            return 1;
        return (raw > DIM) ? DIM : int'(raw);
    endfunction

    function automatic logic [DEF_ELEM_WIDTH-1:0] rand_elem();
        case ($urandom_range(15))
            0:       return ELEM_MIN;
            1:       return ELEM_MAX;
            2:       return '1;
            3:       return '0;
            default: return DEF_ELEM_WIDTH'($urandom);
        endcase
    endfunction

    // Mostly small sizes with zero mixed in. Rows may also take the store
    // size or an oversize value, since those cost no extra loads.
    function automatic logic [CFG_W-1:0] pick_dim(input bit allow_big);
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return '0;
        if (allow_big && r < 30)
            return CFG_W'(DIM);
        if (allow_big && r < 45)
            return CFG_W'($urandom_range(2**CFG_W - 1, DIM + 1));
        return CFG_W'($urandom_range(3, 1));
    endfunction

    // Index below the limit most of the time, anywhere otherwise.
    function automatic logic [IDX_W-1:0] pick_index(input int limit);
        if ($urandom_range(4) == 0)
            return IDX_W'($urandom);
        return IDX_W'($urandom_range(limit - 1));
    endfunction

    // Present one request and return once it is accepted and busy is low. Start is
    // left high so a following request can go out on the next edge.
    task automatic issue_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                                 input logic [IDX_W-1:0] col,
                                 input logic [DEF_ELEM_WIDTH-1:0] value);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start         <= 1'b1;
        opcode        <= op;
        row_index     <= row;
        col_index     <= col;
        element_value <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic load_elem(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col,
                             input logic [DEF_ELEM_WIDTH-1:0] value);
        issue_request(op, row, col, value);
        if (op == OP_LOAD_A && row < rows_eff && col < inner_eff)
            a_written[row][col] = 1'b1;
        if (op == OP_LOAD_B && row < inner_eff && col < cols_eff)
            b_written[row][col] = 1'b1;
    endtask

    // Load whatever the row still lacks, then ask for it.
    task automatic request_row(input logic [IDX_W-1:0] row);
        if (row < rows_eff)
        begin
            for (int l = 0; l < inner_eff; l++)
            begin
                if (!a_written[row][l])
                    load_elem(OP_LOAD_A, row, IDX_W'(l), rand_elem());
                for (int j = 0; j < cols_eff; j++)
                    if (!b_written[l][j])
                        load_elem(OP_LOAD_B, IDX_W'(l), IDX_W'(j), rand_elem());
            end
        end
        issue_request(OP_COMPUTE, row, IDX_W'($urandom), DEF_ELEM_WIDTH'($urandom));
    endtask

    // Wait until every owed result is in and the block has gone quiet.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (results_due != 0 || busy)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] rows_raw, inner_raw, cols_raw);
        logic [CFG_W-1:0]  values [3];
        logic [CIDX_W-1:0] regs [3];
        values = '{rows_raw, inner_raw, cols_raw};
        regs   = '{REG_ROWS, REG_INNER, REG_COLS};
        settle();
        cfg_valid <= 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            cfg_index <= regs[i];
            cfg_data  <= values[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        rows_eff  = clamp_dim(rows_raw);
        inner_eff = clamp_dim(inner_raw);
        cols_eff  = clamp_dim(cols_raw);
    endtask

    initial
    begin : stimulus
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        int               pick;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero rows counts as one, oversize columns as the store size: one
        // row of 64 results, with the most negative value squared in column 0.
        set_dims('0, CFG_W'(1), '1);
        load_elem(OP_LOAD_A, '0, '0, ELEM_MIN);
        load_elem(OP_LOAD_B, '0, '0, ELEM_MIN);
        load_elem(OP_LOAD_B, '0, IDX_W'(DIM - 1), ELEM_MAX);
        request_row('0);
        request_row(IDX_W'(1));
        request_row(IDX_W'(DIM - 1));

        // Small product with extreme elements.
        set_dims(CFG_W'(3), CFG_W'(2), CFG_W'(3));
        load_elem(OP_LOAD_A, '0, '0, ELEM_MIN);
        load_elem(OP_LOAD_A, '0, IDX_W'(1), ELEM_MIN);
        load_elem(OP_LOAD_B, '0, '0, ELEM_MIN);
        load_elem(OP_LOAD_B, IDX_W'(1), '0, ELEM_MIN);
        load_elem(OP_LOAD_B, '0, IDX_W'(1), ELEM_MAX);
        load_elem(OP_LOAD_B, IDX_W'(1), IDX_W'(1), ELEM_MAX);
        load_elem(OP_LOAD_B, '0, IDX_W'(2), '0);
        load_elem(OP_LOAD_B, IDX_W'(1), IDX_W'(2), '1);
        load_elem(OP_LOAD_A, IDX_W'(2), '0, ELEM_MAX);
        load_elem(OP_LOAD_A, IDX_W'(2), IDX_W'(1), '1);

        // Loads outside the sizes and the unused opcode must leave no trace.
        load_elem(OP_LOAD_A, IDX_W'(1), IDX_W'(2), ELEM_MAX);
        load_elem(OP_LOAD_A, '1, '1, '1);
        load_elem(OP_LOAD_B, IDX_W'(2), '0, ELEM_MAX);
        load_elem(OP_LOAD_B, '0, IDX_W'(3), ELEM_MIN);
        issue_request(OP_UNUSED, '1, '1, ELEM_MIN);
        request_row('0);
        request_row(IDX_W'(2));
        request_row(IDX_W'(1));
        request_row(IDX_W'(3));
        request_row('1);

        // Random phases, each with fresh sizes and a sender gap rate chosen by phase.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_dims(pick_dim(1'b1), pick_dim(1'b0), pick_dim(1'b0));
            idle_pct = (p % 2 == 1) ? 64 : ((p == 2) ? 6 : 0);
            for (int it = 0; it < PHASE_ITEMS; it++)
            begin
                pick = $urandom_range(99);
                if (pick < 35)
                begin
                    row = pick_index(rows_eff);
                    col = pick_index(inner_eff);
                    load_elem(OP_LOAD_A, row, col, rand_elem());
                end
                else if (pick < 70)
                begin
                    row = pick_index(inner_eff);
                    col = pick_index(cols_eff);
                    load_elem(OP_LOAD_B, row, col, rand_elem());
                end
                else if (pick < 95)
                    request_row(pick_index(rows_eff));
                else
                    issue_request(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), rand_elem());
            end
        end

        settle();
        if (mismatch_count == 0 && results_due == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/mme_pkg.sv
design/mme_ram.sv
design/matrix_multiply_engine.sv
design/mme_checker.sv
test/matrix_multiply_engine_check.sv
test/matrix_multiply_engine_test.sv
